>>> design/teq_pkg.sv
// ----------------------------------------------------------------------------
// teq_pkg
// Shared types and constants of the timed event queue.
// ----------------------------------------------------------------------------
package teq_pkg;

   localparam int DEF_NUM_EVENTS = 16;
   localparam int DEF_CYCLE_BITS = 31;

   localparam int ID_W    = 4;
   localparam int CYC_W   = 31;
   localparam int COUNT_W = 5;
   localparam int CMD_W   = 2;

   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 80;

   typedef enum logic [CMD_W-1:0] {
      CMD_SCHEDULE = 2'd0,
      CMD_REMOVE   = 2'd1,
      CMD_POLL     = 2'd2,
      CMD_SETBACK  = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_UPDATE,
      ST_SWEEP,
      ST_FIND,
      ST_RETIRE,
      ST_SCAN,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic clear;
      logic sample;
      logic active;
      logic hit;
   } scan_ctl_type;

endpackage

>>> design/teq_store.sv
// ----------------------------------------------------------------------------
// teq_store
// Due cycle memory with one write and one registered read port, plus the
// active marks held in flip-flops.
// ----------------------------------------------------------------------------
module teq_store #(
   parameter int NUM_EVENTS = teq_pkg::DEF_NUM_EVENTS,
   parameter int CYCLE_BITS = teq_pkg::DEF_CYCLE_BITS,
   parameter int IDX_W      = (NUM_EVENTS > 1) ? $clog2(NUM_EVENTS) : 1
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [IDX_W-1:0]      rd_addr,
   output logic [CYCLE_BITS-1:0] rd_data,
   input  logic                  wr_en,
   input  logic [IDX_W-1:0]      wr_addr,
   input  logic [CYCLE_BITS-1:0] wr_data,
   input  logic                  act_set,
   input  logic                  act_clr,
   input  logic [IDX_W-1:0]      act_idx,
   output logic [NUM_EVENTS-1:0] active
);
   import teq_pkg::*;

   logic [CYCLE_BITS-1:0] mem [NUM_EVENTS];
   logic [CYCLE_BITS-1:0] rd_data_ff;
   logic [NUM_EVENTS-1:0] act_ff;
   logic [NUM_EVENTS-1:0] act_in;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   always_comb begin
      act_in = act_ff;
      if (act_set) begin
         act_in[act_idx] = 1'b1;
      end else if (act_clr) begin
         act_in[act_idx] = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         act_ff <= '0;
      end else begin
         act_ff <= act_in;
      end
   end

   assign rd_data = rd_data_ff;
   assign active  = act_ff;

endmodule

>>> design/teq_scan.sv
// ----------------------------------------------------------------------------
// teq_scan
// Accumulates the earliest active entry, the active count and the queried
// entry's due cycle from one memory sample per cycle.
// ----------------------------------------------------------------------------
module teq_scan #(
   parameter int CYCLE_BITS = teq_pkg::DEF_CYCLE_BITS,
   parameter int IDX_W      = 4
) (
   input  logic                        clock,
   input  teq_pkg::scan_ctl_type       ctl,
   input  logic [IDX_W-1:0]            smp_idx,
   input  logic [CYCLE_BITS-1:0]       smp_data,
   output logic                        min_vld,
   output logic [CYCLE_BITS-1:0]       min_cyc,
   output logic [IDX_W-1:0]            min_idx,
   output logic [teq_pkg::COUNT_W-1:0] count,
   output logic                        ev_act,
   output logic [CYCLE_BITS-1:0]       ev_cyc
);
   import teq_pkg::*;

   logic                  min_vld_ff;
   logic [CYCLE_BITS-1:0] min_cyc_ff;
   logic [IDX_W-1:0]      min_idx_ff;
   logic [COUNT_W-1:0]    cnt_ff;
   logic                  ev_act_ff;
   logic [CYCLE_BITS-1:0] ev_cyc_ff;

   always_ff @(posedge clock) begin
      if (ctl.clear) begin
         min_vld_ff <= 1'b0;
         min_cyc_ff <= '0;
         min_idx_ff <= '0;
         cnt_ff     <= '0;
         ev_act_ff  <= 1'b0;
         ev_cyc_ff  <= '0;
      end else if (ctl.sample && ctl.active) begin
         if (!min_vld_ff || (smp_data < min_cyc_ff)) begin
            min_vld_ff <= 1'b1;
            min_cyc_ff <= smp_data;
            min_idx_ff <= smp_idx;
         end
         if (cnt_ff != '1) begin
            cnt_ff <= cnt_ff + COUNT_W'(1);
         end
         if (ctl.hit) begin
            ev_act_ff <= 1'b1;
            ev_cyc_ff <= smp_data;
         end
      end
   end

   assign min_vld = min_vld_ff;
   assign min_cyc = min_cyc_ff;
   assign min_idx = min_idx_ff;
   assign count   = cnt_ff;
   assign ev_act  = ev_act_ff;
   assign ev_cyc  = ev_cyc_ff;

endmodule

>>> design/timed_event_queue.sv
// ----------------------------------------------------------------------------
// timed_event_queue
// Keeps one due cycle per event id with an active mark; schedules, removes,
// polls the earliest due event and sets back all due cycles.
//
//   Channel | Direction | tuser | tdata fields (lowest bit first)
//   req_    | in        | cmd   | event_id, cycle_value
//   rsp_    | out       | -     | polled_valid, polled_event, removed,
//           |           |       | event_active, event_cycle, next_valid,
//           |           |       | next_cycle, scheduled_count
//
// One item at a time. Schedule and remove pass through the update and scan
// states, poll through update, find, retire and scan, and set back through
// update, sweep and scan, each ending in done; every sweep and scan walks the
// due cycle memory through its single read port one entry per cycle.
// Reset clears the active marks and the control state only.
// A result waiting on rsp_tready holds the next item in its final cycle.
// ----------------------------------------------------------------------------
module timed_event_queue #(
   parameter int NUM_EVENTS = teq_pkg::DEF_NUM_EVENTS,
   parameter int CYCLE_BITS = teq_pkg::DEF_CYCLE_BITS
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // tuser: cmd
   input  logic [teq_pkg::CMD_W-1:0]          req_tuser,
   // tdata: event_id, cycle_value
   input  logic [teq_pkg::REQ_DATA_W-1:0]     req_tdata,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // tdata: polled_valid, polled_event, removed, event_active, event_cycle,
   // next_valid, next_cycle, scheduled_count
   output logic [teq_pkg::RSP_DATA_W-1:0]     rsp_tdata
);
   import teq_pkg::*;

   localparam int IDX_W = (NUM_EVENTS > 1) ? $clog2(NUM_EVENTS) : 1;
   localparam int CNT_W = $clog2(NUM_EVENTS + 1);

   state_type             state_ff, state_in;
   logic [CNT_W-1:0]      ptr_ff, ptr_in;
   logic                  smp_vld_ff, smp_vld_in;
   logic [IDX_W-1:0]      smp_idx_ff, smp_idx_in;
   cmd_type               cmd_ff;
   logic [ID_W-1:0]       id_ff;
   logic                  id_ok_ff;
   logic [CYCLE_BITS-1:0] val_ff;
   logic                  removed_ff, removed_in;
   logic                  pv_ff, pv_in;
   logic [ID_W-1:0]       pe_ff, pe_in;
   logic                  rsp_vld_ff, rsp_vld_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff;

   logic                  accept;
   logic                  load_rsp;
   logic                  issue;
   logic [IDX_W-1:0]      id_idx;
   logic [IDX_W-1:0]      rd_addr;
   logic [CYCLE_BITS-1:0] rd_data;
   logic                  wr_en;
   logic [IDX_W-1:0]      wr_addr;
   logic [CYCLE_BITS-1:0] wr_data;
   logic                  act_set, act_clr;
   logic [IDX_W-1:0]      act_idx;
   logic [NUM_EVENTS-1:0] active;
   scan_ctl_type          scan_ctl;
   logic                  min_vld;
   logic [CYCLE_BITS-1:0] min_cyc;
   logic [IDX_W-1:0]      min_idx;
   logic [COUNT_W-1:0]    count;
   logic                  ev_act;
   logic [CYCLE_BITS-1:0] ev_cyc;
   logic [RSP_DATA_W-1:0] rsp_word;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign issue      = (ptr_ff < CNT_W'(NUM_EVENTS));
   assign id_idx     = IDX_W'(id_ff);
   assign rd_addr    = ptr_ff[IDX_W-1:0];

   always_comb begin
      state_in    = state_ff;
      ptr_in      = ptr_ff;
      smp_vld_in  = 1'b0;
      smp_idx_in  = ptr_ff[IDX_W-1:0];
      removed_in  = removed_ff;
      pv_in       = pv_ff;
      pe_in       = pe_ff;
      wr_en       = 1'b0;
      wr_addr     = smp_idx_ff;
      wr_data     = (rd_data > val_ff) ? (rd_data - val_ff) : '0;
      act_set     = 1'b0;
      act_clr     = 1'b0;
      act_idx     = id_idx;
      scan_ctl    = '{clear: 1'b0, sample: 1'b0, active: active[smp_idx_ff],
                      hit: id_ok_ff && (smp_idx_ff == id_idx)};
      load_rsp    = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            ptr_in        = '0;
            removed_in    = 1'b0;
            pv_in         = 1'b0;
            pe_in         = '0;
            scan_ctl.clear = 1'b1;
            unique case (cmd_ff)
               CMD_SCHEDULE: begin
                  wr_en    = id_ok_ff;
                  wr_addr  = id_idx;
                  wr_data  = val_ff;
                  act_set  = id_ok_ff;
                  state_in = ST_SCAN;
               end
               CMD_REMOVE: begin
                  removed_in = id_ok_ff && active[id_idx];
                  act_clr    = id_ok_ff;
                  state_in   = ST_SCAN;
               end
               CMD_POLL: begin
                  state_in = ST_FIND;
               end
               default: begin
                  state_in = ST_SWEEP;
               end
            endcase
         end
         ST_SWEEP: begin
            wr_en = smp_vld_ff;
            if (issue) begin
               ptr_in     = ptr_ff + CNT_W'(1);
               smp_vld_in = 1'b1;
            end else if (!smp_vld_ff) begin
               ptr_in         = '0;
               scan_ctl.clear = 1'b1;
               state_in       = ST_SCAN;
            end
         end
         ST_FIND, ST_SCAN: begin
            scan_ctl.sample = smp_vld_ff;
            if (issue) begin
               ptr_in     = ptr_ff + CNT_W'(1);
               smp_vld_in = 1'b1;
            end else if (!smp_vld_ff) begin
               state_in = (state_ff == ST_FIND) ? ST_RETIRE : ST_DONE;
            end
         end
         ST_RETIRE: begin
            ptr_in         = '0;
            scan_ctl.clear = 1'b1;
            act_idx        = min_idx;
            if (min_vld && (min_cyc <= val_ff)) begin
               act_clr = 1'b1;
               pv_in   = 1'b1;
               pe_in   = ID_W'(min_idx);
            end
            state_in = ST_SCAN;
         end
         ST_DONE: begin
            if (!rsp_vld_ff || rsp_tready) begin
               load_rsp = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_word = '0;
      rsp_word[0]     = pv_ff;
      rsp_word[4:1]   = pe_ff;
      rsp_word[5]     = removed_ff;
      rsp_word[6]     = ev_act;
      rsp_word[37:7]  = CYC_W'(ev_cyc);
      rsp_word[38]    = min_vld;
      rsp_word[69:39] = CYC_W'(min_cyc);
      rsp_word[74:70] = count;
   end

   always_comb begin
      rsp_vld_in = rsp_vld_ff;
      if (load_rsp) begin
         rsp_vld_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         ptr_ff     <= '0;
         smp_vld_ff <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         ptr_ff     <= ptr_in;
         smp_vld_ff <= smp_vld_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      smp_idx_ff <= smp_idx_in;
      removed_ff <= removed_in;
      pv_ff      <= pv_in;
      pe_ff      <= pe_in;
      if (accept) begin
         cmd_ff   <= cmd_type'(req_tuser);
         id_ff    <= req_tdata[ID_W-1:0];
         id_ok_ff <= (32'(req_tdata[ID_W-1:0]) < 32'(NUM_EVENTS));
         val_ff   <= CYCLE_BITS'(req_tdata[ID_W+CYC_W-1:ID_W]);
      end
      if (load_rsp) begin
         rsp_data_ff <= rsp_word;
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = rsp_data_ff;

   teq_store #(
      .NUM_EVENTS (NUM_EVENTS),
      .CYCLE_BITS (CYCLE_BITS),
      .IDX_W      (IDX_W)
   ) u_store (
      .clock   (clock),
      .reset   (reset),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .act_set (act_set),
      .act_clr (act_clr),
      .act_idx (act_idx),
      .active  (active)
   );

   teq_scan #(
      .CYCLE_BITS (CYCLE_BITS),
      .IDX_W      (IDX_W)
   ) u_scan (
      .clock    (clock),
      .ctl      (scan_ctl),
      .smp_idx  (smp_idx_ff),
      .smp_data (rd_data),
      .min_vld  (min_vld),
      .min_cyc  (min_cyc),
      .min_idx  (min_idx),
      .count    (count),
      .ev_act   (ev_act),
      .ev_cyc   (ev_cyc)
   );

endmodule
